FILE: design/amwc_pkg.sv
// Shared types and constants for the accelerometer window conditioner.
// No dependencies; used by amwc_lane, amwc_rms and the top level.
`default_nettype none
package amwc_pkg;

  localparam int FRAC_BITS = 4;
  localparam int SHIFT_K   = 28 - FRAC_BITS;
  localparam int SAMPLE_W  = 16;
  localparam int CLEAN_W   = 16;
  localparam int RMS_W     = 15;
  localparam int CFG_W     = 16;
  localparam int IDX_W     = 3;

  localparam logic [RMS_W-1:0] RMS_MAX = 15'h7fff;

  // register map
  localparam logic [IDX_W-1:0] REG_WINDOW_LEN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_EVAL_INTERVAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_SMOOTH        = 3'd2;
  localparam logic [IDX_W-1:0] REG_POST_GAIN     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CLIP          = 3'd4;
  localparam logic [IDX_W-1:0] REG_START_THR     = 3'd5;
  localparam logic [IDX_W-1:0] REG_STOP_THR      = 3'd6;
  localparam logic [IDX_W-1:0] REG_EVAL_EN       = 3'd7;

  localparam logic [8:0]  RST_WINDOW_LEN = 9'd128;
  localparam logic [7:0]  RST_INTERVAL   = 8'd32;
  localparam logic [15:0] RST_SMOOTH     = 16'd58982;
  localparam logic [15:0] RST_GAIN       = 16'd6144;
  localparam logic [14:0] RST_CLIP       = 15'd8000;
  localparam logic [14:0] RST_START      = 15'd320;
  localparam logic [14:0] RST_STOP       = 15'd80;

  typedef enum logic [3:0] {
    S_IDLE, S_M1, S_M2, S_M3, S_SUM, S_DIFF, S_M4, S_M5, S_RND, S_CLIP,
    S_WRITE, S_SCAN, S_DRAIN, S_RMS, S_DONE
  } state_t;

  typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rms_state_t;

  typedef struct packed {
    state_t step;
    logic   ram_we;
    logic   rd_en;
    logic   sq_en;
    logic   acc_en;
    logic   acc_clr;
  } lane_ctl_t;

endpackage
`default_nettype wire

FILE: design/amwc_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module amwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: design/amwc_lane.sv
// One axis lane: DC tracking, gain, clip, window RAM and sum of squares.
// Depends on amwc_pkg and amwc_ram.
`default_nettype none
module amwc_lane #(
  parameter int MAX_WINDOW = 256,
  parameter int AW         = 8,
  parameter int SQW        = 39
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire amwc_pkg::lane_ctl_t                 ctl,
  input  wire logic signed [amwc_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [15:0]                         alpha,
  input  wire logic [15:0]                         gain,
  input  wire logic [14:0]                         clip_lim,
  input  wire logic [AW-1:0]                       wr_addr,
  input  wire logic [AW-1:0]                       rd_addr,
  output logic signed [amwc_pkg::CLEAN_W-1:0]      clean,
  output logic [SQW-1:0]                           sq_sum
);
  logic signed [32:0] avg;
  logic [31:0]        p1;
  logic signed [33:0] p2, p3, d;
  logic [31:0]        q1;
  logic signed [34:0] q2;
  logic signed [51:0] cshift;
  logic signed [51:0] acc_sum, rnd_sum, lim52;
  logic [16:0]        inv_alpha;
  logic [15:0]        rdata;
  logic [30:0]        sq;

  assign inv_alpha = 17'h10000 - {1'b0, alpha};
  assign acc_sum = ({{18{p2[33]}}, p2} <<< 16) + $signed({20'd0, p1})
                 + ({{18{p3[33]}}, p3} <<< 16) + 52'sd32768;
  assign rnd_sum = ({{17{q2[34]}}, q2} <<< 16) + $signed({20'd0, q1})
                 + (52'sd1 <<< (amwc_pkg::SHIFT_K - 1));
  assign lim52 = $signed({37'd0, clip_lim});

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (ctl.step == amwc_pkg::S_SUM) begin
      avg <= acc_sum[48:16];
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.step)
      amwc_pkg::S_M1: p1 <= alpha * avg[15:0];
      amwc_pkg::S_M2: p2 <= $signed({1'b0, alpha}) * $signed(avg[32:16]);
      amwc_pkg::S_M3: p3 <= $signed({1'b0, inv_alpha}) * sample;
      amwc_pkg::S_DIFF: d <= $signed({{2{sample[15]}}, sample, 16'd0})
                           - $signed({avg[32], avg});
      amwc_pkg::S_M4: q1 <= d[15:0] * gain;
      amwc_pkg::S_M5: q2 <= $signed(d[33:16]) * $signed({1'b0, gain});
      amwc_pkg::S_RND: cshift <= rnd_sum >>> amwc_pkg::SHIFT_K;
      amwc_pkg::S_CLIP: begin
        if (cshift > lim52) begin
          clean <= lim52[15:0];
        end else if (cshift < -lim52) begin
          clean <= 16'(-lim52);
        end else begin
          clean <= cshift[15:0];
        end
      end
      default: ;
    endcase
  end

  amwc_ram #(.WIDTH(amwc_pkg::CLEAN_W), .DEPTH(MAX_WINDOW)) u_win (
    .clk  (clk),
    .we   (ctl.ram_we),
    .waddr(wr_addr),
    .wdata(clean),
    .re   (ctl.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // square then accumulate, one stored value per cycle
  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      sq <= 31'($signed(rdata) * $signed(rdata));
    end
    if (ctl.acc_clr) begin
      sq_sum <= '0;
    end else if (ctl.acc_en) begin
      sq_sum <= sq_sum + SQW'(sq);
    end
  end
endmodule
`default_nettype wire

FILE: design/amwc_rms.sv
// Merge stage: adds lane sums, divides by the value count, takes the root.
// Depends on amwc_pkg.
`default_nettype none
module amwc_rms #(
  parameter int MAX_WINDOW = 256,
  parameter int SQW        = 39,
  parameter int LW         = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [SQW-1:0]             sum_x,
  input  wire logic [SQW-1:0]             sum_y,
  input  wire logic [SQW-1:0]             sum_z,
  input  wire logic [LW-1:0]              len,
  output logic                            done,
  output logic [amwc_pkg::RMS_W-1:0]      rms
);
  localparam int TW = SQW + 2;
  localparam int QW = TW + (TW % 2);
  localparam int RW = QW / 2;
  localparam int DW = $clog2(3 * MAX_WINDOW + 1);
  localparam int CW = $clog2(QW + 1);

  amwc_pkg::rms_state_t state, state_next;
  logic [QW-1:0] q;
  logic [DW-1:0] div, rem;
  logic [DW:0]   rem_sh;
  logic [RW:0]   srem;
  logic [RW+2:0] srem_sh, trial;
  logic [RW-1:0] root;
  logic [CW-1:0] cnt;
  logic          div_last, sqrt_last;

  assign rem_sh  = {rem, q[QW-1]};
  assign srem_sh = {srem, q[QW-1:QW-2]};
  assign trial   = {1'b0, root, 2'b01};

  always_comb begin
    div_last  = (state == amwc_pkg::R_DIV)  && (cnt == CW'(QW - 1));
    sqrt_last = (state == amwc_pkg::R_SQRT) && (cnt == CW'(RW - 1));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      amwc_pkg::R_IDLE: if (start) state_next = amwc_pkg::R_DIV;
      amwc_pkg::R_DIV:  if (div_last) state_next = amwc_pkg::R_SQRT;
      amwc_pkg::R_SQRT: if (sqrt_last) state_next = amwc_pkg::R_IDLE;
      default:          state_next = amwc_pkg::R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= amwc_pkg::R_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= sqrt_last;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      amwc_pkg::R_IDLE: begin
        if (start) begin
          q   <= QW'(sum_x) + QW'(sum_y) + QW'(sum_z);
          div <= DW'({len, 1'b0}) + DW'(len);
          rem <= '0;
          cnt <= '0;
        end
      end
      amwc_pkg::R_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_sh >= {1'b0, div}) begin
          rem <= DW'(rem_sh - {1'b0, div});
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[DW-1:0];
          q   <= {q[QW-2:0], 1'b0};
        end
        cnt  <= div_last ? '0 : cnt + 1'b1;
        srem <= '0;
        root <= '0;
      end
      amwc_pkg::R_SQRT: begin
        // digit-by-digit root, two radicand bits per cycle
        if (srem_sh >= trial) begin
          srem <= (RW+1)'(srem_sh - trial);
          root <= {root[RW-2:0], 1'b1};
        end else begin
          srem <= srem_sh[RW:0];
          root <= {root[RW-2:0], 1'b0};
        end
        q   <= {q[QW-3:0], 2'b00};
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  assign rms = (root > RW'(amwc_pkg::RMS_MAX)) ? amwc_pkg::RMS_MAX
                                               : root[amwc_pkg::RMS_W-1:0];

`ifndef SYNTHESIS
  a_done_after_sqrt: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == amwc_pkg::R_SQRT)
    else $error("rms done without root step");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == amwc_pkg::R_DIV) |-> (div != '0))
    else $error("zero divisor");
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    (state == amwc_pkg::R_DIV) |-> (rem < div))
    else $error("division remainder out of range");
`endif
endmodule
`default_nettype wire

FILE: design/accel_motion_window_conditioner.sv
// Top level of the accelerometer conditioner with windowed RMS motion flag.
// Depends on amwc_pkg, amwc_lane, amwc_rms (and amwc_ram through the lanes).
//
// Usage notes:
//  - Input channel in_valid/in_ready carries one X/Y/Z sample per transaction.
//    Output channel out_valid/out_ready returns one result transaction each.
//  - Three lanes, one per axis, run the DC removal, gain and clip in parallel,
//    at most one multiply per step (M1, M2, M3, SUM, DIFF, M4, M5, RND, CLIP).
//  - Without an evaluation an item passes the lane steps, then WRITE and DONE.
//  - With an evaluation the lanes walk their window RAMs one entry a cycle
//    (SCAN), empty their square and accumulate registers (DRAIN), then the
//    merge unit divides the QW-bit sum of squares (QW is 33 +
//    log2(MAX_WINDOW) rounded up to even) and takes the root (RMS).
//  - One item is in flight at a time; in_ready is high only when idle.
//  - The result register frees the input side: a new transaction can be taken
//    while the last result still waits; a finished item holds in its final
//    state until the receiver takes the previous result.
//  - Reset (rst, synchronous) loads the register defaults, clears averages,
//    write index, fill count, phase and motion flag. Window RAM is not cleared;
//    it is always refilled before it is read.
//  - Configuration writes (cfg_write) are taken in any cycle; writing the
//    window length restarts filling.
`default_nettype none
module accel_motion_window_conditioner #(
  parameter int MAX_WINDOW = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [amwc_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [amwc_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [15:0]         x_sample,
  input  wire logic signed [15:0]         y_sample,
  input  wire logic signed [15:0]         z_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [15:0]              x_clean,
  output logic signed [15:0]              y_clean,
  output logic signed [15:0]              z_clean,
  output logic                            evaluated,
  output logic [14:0]                     window_rms,
  output logic                            moving
);
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int SQW = 31 + AW;

  // configuration registers
  logic [8:0]  window_len;
  logic [7:0]  eval_interval;
  logic [15:0] smooth_factor, post_gain;
  logic [14:0] clip_limit, start_threshold, stop_threshold;
  logic        eval_enable;

  logic [LW-1:0] len_eff;
  logic [7:0]    interval_eff;

  amwc_pkg::state_t state, state_next;
  logic [AW-1:0] write_index, widx_use, widx_next, scan_addr;
  logic [LW-1:0] fill_count, fill_next;
  logic [7:0]    phase_count, phase_next;
  logic          tick, eval_now, do_eval, motion_flag;
  logic          rd_v, sq_v, scan_last;
  logic          rms_start, rms_done, load_out;
  logic [14:0]   rms_val;
  logic signed [15:0] samp [3];
  logic signed [15:0] clean [3];
  logic [SQW-1:0]     sums [3];
  amwc_pkg::lane_ctl_t ctl;

  // effective window length and interval
  always_comb begin
    if (window_len == 9'd0) begin
      len_eff = LW'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(window_len);
    end
    interval_eff = (eval_interval == 8'd0) ? 8'd1 : eval_interval;
  end

  always_comb begin
    widx_use  = (LW'(write_index) >= len_eff) ? '0 : write_index;
    widx_next = (LW'(widx_use) + LW'(1) >= len_eff) ? '0 : widx_use + 1'b1;
    fill_next = (fill_count < len_eff) ? fill_count + 1'b1 : fill_count;
    tick      = ({1'b0, phase_count} + 9'd1) >= {1'b0, interval_eff};
    phase_next = tick ? 8'd0 : phase_count + 8'd1;
    eval_now  = eval_enable && (fill_next >= len_eff) && tick;
    scan_last = (LW'(scan_addr) + LW'(1)) == len_eff;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      amwc_pkg::S_IDLE:  if (in_valid) state_next = amwc_pkg::S_M1;
      amwc_pkg::S_M1:    state_next = amwc_pkg::S_M2;
      amwc_pkg::S_M2:    state_next = amwc_pkg::S_M3;
      amwc_pkg::S_M3:    state_next = amwc_pkg::S_SUM;
      amwc_pkg::S_SUM:   state_next = amwc_pkg::S_DIFF;
      amwc_pkg::S_DIFF:  state_next = amwc_pkg::S_M4;
      amwc_pkg::S_M4:    state_next = amwc_pkg::S_M5;
      amwc_pkg::S_M5:    state_next = amwc_pkg::S_RND;
      amwc_pkg::S_RND:   state_next = amwc_pkg::S_CLIP;
      amwc_pkg::S_CLIP:  state_next = amwc_pkg::S_WRITE;
      amwc_pkg::S_WRITE: state_next = eval_now ? amwc_pkg::S_SCAN : amwc_pkg::S_DONE;
      amwc_pkg::S_SCAN:  if (scan_last) state_next = amwc_pkg::S_DRAIN;
      amwc_pkg::S_DRAIN: if (!rd_v && !sq_v) state_next = amwc_pkg::S_RMS;
      amwc_pkg::S_RMS:   if (rms_done) state_next = amwc_pkg::S_DONE;
      amwc_pkg::S_DONE:  if (!out_valid || out_ready) state_next = amwc_pkg::S_IDLE;
      default:           state_next = amwc_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = (state == amwc_pkg::S_IDLE);
    rms_start   = (state == amwc_pkg::S_DRAIN) && !rd_v && !sq_v;
    load_out    = (state == amwc_pkg::S_DONE) && (!out_valid || out_ready);
    ctl.step    = state;
    ctl.ram_we  = (state == amwc_pkg::S_WRITE);
    ctl.rd_en   = (state == amwc_pkg::S_SCAN);
    ctl.sq_en   = rd_v;
    ctl.acc_en  = sq_v;
    ctl.acc_clr = (state == amwc_pkg::S_WRITE);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len      <= amwc_pkg::RST_WINDOW_LEN;
      eval_interval   <= amwc_pkg::RST_INTERVAL;
      smooth_factor   <= amwc_pkg::RST_SMOOTH;
      post_gain       <= amwc_pkg::RST_GAIN;
      clip_limit      <= amwc_pkg::RST_CLIP;
      start_threshold <= amwc_pkg::RST_START;
      stop_threshold  <= amwc_pkg::RST_STOP;
      eval_enable     <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        amwc_pkg::REG_WINDOW_LEN:    window_len      <= cfg_data[8:0];
        amwc_pkg::REG_EVAL_INTERVAL: eval_interval   <= cfg_data[7:0];
        amwc_pkg::REG_SMOOTH:        smooth_factor   <= cfg_data;
        amwc_pkg::REG_POST_GAIN:     post_gain       <= cfg_data;
        amwc_pkg::REG_CLIP:          clip_limit      <= cfg_data[14:0];
        amwc_pkg::REG_START_THR:     start_threshold <= cfg_data[14:0];
        amwc_pkg::REG_STOP_THR:      stop_threshold  <= cfg_data[14:0];
        amwc_pkg::REG_EVAL_EN:       eval_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= amwc_pkg::S_IDLE;
      write_index <= '0;
      fill_count  <= '0;
      phase_count <= '0;
      motion_flag <= 1'b0;
      do_eval     <= 1'b0;
      rd_v        <= 1'b0;
      sq_v        <= 1'b0;
      scan_addr   <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= ctl.rd_en;
      sq_v  <= rd_v;
      if (cfg_write && cfg_index == amwc_pkg::REG_WINDOW_LEN) begin
        write_index <= '0;
        fill_count  <= '0;
      end else if (state == amwc_pkg::S_WRITE) begin
        write_index <= widx_next;
        fill_count  <= fill_next;
      end
      if (state == amwc_pkg::S_WRITE) begin
        phase_count <= phase_next;
        do_eval     <= eval_now;
        scan_addr   <= '0;
      end else if (state == amwc_pkg::S_SCAN) begin
        scan_addr <= scan_addr + 1'b1;
      end
      // hysteresis on a fresh RMS value
      if (rms_done) begin
        if (!motion_flag && (rms_val > start_threshold)) begin
          motion_flag <= 1'b1;
        end else if (motion_flag && (rms_val < stop_threshold)) begin
          motion_flag <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      samp[0] <= x_sample;
      samp[1] <= y_sample;
      samp[2] <= z_sample;
    end
    if (load_out) begin
      x_clean    <= clean[0];
      y_clean    <= clean[1];
      z_clean    <= clean[2];
      evaluated  <= do_eval;
      window_rms <= do_eval ? rms_val : 15'd0;
      moving     <= motion_flag;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_lane
    amwc_lane #(.MAX_WINDOW(MAX_WINDOW), .AW(AW), .SQW(SQW)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .sample  (samp[a]),
      .alpha   (smooth_factor),
      .gain    (post_gain),
      .clip_lim(clip_limit),
      .wr_addr (widx_use),
      .rd_addr (scan_addr),
      .clean   (clean[a]),
      .sq_sum  (sums[a])
    );
  end

  amwc_rms #(.MAX_WINDOW(MAX_WINDOW), .SQW(SQW), .LW(LW)) u_rms (
    .clk  (clk),
    .rst  (rst),
    .start(rms_start),
    .sum_x(sums[0]),
    .sum_y(sums[1]),
    .sum_z(sums[2]),
    .len  (len_eff),
    .done (rms_done),
    .rms  (rms_val)
  );

`ifndef SYNTHESIS
  a_rms_zero_unless_eval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !evaluated) |-> (window_rms == 15'd0))
    else $error("rms reported without evaluation");
  a_done_in_rms_state: assert property (@(posedge clk) disable iff (rst)
    rms_done |-> (state == amwc_pkg::S_RMS))
    else $error("rms result outside its wait state");
  a_index_in_window: assert property (@(posedge clk) disable iff (rst)
    (LW'(write_index) < len_eff) || (state == amwc_pkg::S_IDLE))
    else $error("write index beyond window");
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == amwc_pkg::S_SCAN) |-> (fill_count == len_eff))
    else $error("window scanned before full");
`endif
endmodule
`default_nettype wire
